### rtl/triangle_column_span_rasterizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle column span rasterizer
// Implication checks, clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_COLUMN_SPAN_RASTERIZER_UNIT_ASSERT_SVH
`define TRIANGLE_COLUMN_SPAN_RASTERIZER_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define TCSR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcsr: same-cycle check failed");
// next-cycle implication
`define TCSR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcsr: next-cycle check failed");
`else
`define TCSR_ASSERT_NOW(name, ante, cons)
`define TCSR_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### rtl/tcsr_pkg.sv
// ----------------------------------------------------------------------------
// tcsr_pkg
// Widths, register codes and item types shared by the span rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcsr_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int COORD_INT_BITS  = 12;
  localparam int CW      = COORD_INT_BITS + COORD_FRAC_BITS;  // vertex coordinate
  localparam int COL_W   = 12;
  localparam int ROW_W   = 13;
  localparam int COLOR_W = 24;
  localparam int CFG_W   = (CW > COLOR_W) ? CW : COLOR_W;
  localparam int XW      = COL_W + COORD_FRAC_BITS;           // column in fixed point
  localparam int DW      = ((CW > XW) ? CW : XW) + 1;         // coordinate differences
  localparam int P1W     = CW + DW;                           // y * dx
  localparam int P2W     = 2 * DW;                            // dy * offset
  localparam int NW      = 2 * DW + 1;                        // numerator magnitude
  localparam int DENW    = DW + COORD_FRAC_BITS;              // denominator
  localparam int QB      = COORD_INT_BITS + 1;                // quotient bits
  localparam int SW      = ((QB + 2) > (ROW_W + 1)) ? (QB + 2) : (ROW_W + 1);
  localparam int ROW_MIN = -4096;
  localparam int ROW_MAX = 4095;
  localparam int QUEUE_DEPTH = 4;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_VA_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_VA_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_VB_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_VB_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_VC_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_VC_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FILL = 3'd6;

  localparam int SEG_LO = 0;  // lower edge, ceiling
  localparam int SEG_HI = 1;  // upper edge, floor

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } tcsr_vtx_t;

  typedef struct packed {
    tcsr_vtx_t va;
    tcsr_vtx_t vb;
    tcsr_vtx_t vc;
  } tcsr_tri_t;

  typedef struct packed {
    logic signed [CW-1:0] py;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] ofs;
  } tcsr_seg_t;

  typedef struct packed {
    logic signed [COL_W-1:0] x;
    logic                    go;
    tcsr_seg_t [1:0]         seg;
  } tcsr_item_t;

endpackage

### rtl/tcsr_if.sv
// ----------------------------------------------------------------------------
// tcsr channel interfaces
// Column words in, span words out, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcsr_col_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tcsr_pkg::COL_W-1:0]     column;
  modport source (output valid, output column, input ready);
  modport sink   (input valid, input column, output ready);
endinterface

interface tcsr_span_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tcsr_pkg::COL_W-1:0]     column_out;
  logic signed [tcsr_pkg::ROW_W-1:0]     first_row;
  logic signed [tcsr_pkg::ROW_W-1:0]     last_row;
  logic                                  covered;
  logic        [tcsr_pkg::COLOR_W-1:0]   color;
  modport source (output valid, output column_out, output first_row, output last_row,
                  output covered, output color, input ready);
  modport sink   (input valid, input column_out, input first_row, input last_row,
                  input covered, input color, output ready);
endinterface

### rtl/tcsr_front.sv
// ----------------------------------------------------------------------------
// tcsr_front
// Rotate the vertices, pick lower and upper edges for one column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcsr_front (
  input  tcsr_pkg::tcsr_tri_t                tri_i,
  input  logic signed [tcsr_pkg::COL_W-1:0]  column_i,
  output tcsr_pkg::tcsr_item_t               item_o
);

  localparam int DW = tcsr_pkg::DW;

  function automatic tcsr_pkg::tcsr_seg_t mk_seg(input tcsr_pkg::tcsr_vtx_t p,
                                                 input tcsr_pkg::tcsr_vtx_t q,
                                                 input logic signed [DW-1:0] xf);
    tcsr_pkg::tcsr_seg_t s;
    s.py  = p.y;
    s.dx  = DW'(q.x) - DW'(p.x);
    s.dy  = DW'(q.y) - DW'(p.y);
    s.ofs = xf - DW'(p.x);
    return s;
  endfunction

  always_comb begin
    tcsr_pkg::tcsr_vtx_t a, b, c, lo0, lo1, hi0, hi1;
    logic signed [DW-1:0] xf, rgt;
    logic ok;
    xf = DW'(column_i) <<< tcsr_pkg::COORD_FRAC_BITS;

    // left-most vertex first, ties to a then b, winding kept
    if (tri_i.va.x <= tri_i.vb.x && tri_i.va.x <= tri_i.vc.x) begin
      a = tri_i.va; b = tri_i.vb; c = tri_i.vc;
    end else if (tri_i.vb.x <= tri_i.va.x && tri_i.vb.x <= tri_i.vc.x) begin
      a = tri_i.vb; b = tri_i.vc; c = tri_i.va;
    end else begin
      a = tri_i.vc; b = tri_i.va; c = tri_i.vb;
    end

    ok  = 1'b1;
    lo0 = a; lo1 = b; hi0 = a; hi1 = c;
    rgt = DW'(c.x);
    if (a.x == c.x) begin
      rgt = DW'(b.x); lo0 = a; lo1 = b; hi0 = c; hi1 = b;
      if (a.x == b.x) begin
        ok = 1'b0;
      end
    end else if (a.x == b.x) begin
      rgt = DW'(c.x); lo0 = b; lo1 = c; hi0 = a; hi1 = c;
    end else if (b.x == c.x) begin
      rgt = DW'(c.x); lo0 = a; lo1 = b; hi0 = a; hi1 = c;
    end else if (b.x < c.x) begin
      rgt = DW'(c.x); hi0 = a; hi1 = c;
      if (xf <= DW'(b.x)) begin
        lo0 = a; lo1 = b;
      end else begin
        lo0 = b; lo1 = c;
      end
    end else begin
      rgt = DW'(b.x); lo0 = a; lo1 = b;
      if (xf <= DW'(c.x)) begin
        hi0 = a; hi1 = c;
      end else begin
        hi0 = c; hi1 = b;
      end
    end

    item_o.x = column_i;
    item_o.seg[tcsr_pkg::SEG_LO] = mk_seg(lo0, lo1, xf);
    item_o.seg[tcsr_pkg::SEG_HI] = mk_seg(hi0, hi1, xf);
    item_o.go = ok && (xf >= DW'(a.x)) && (xf <= rgt) &&
                (lo0.x != lo1.x) && (hi0.x != hi1.x);
  end

endmodule

### rtl/tcsr_queue.sv
// ----------------------------------------------------------------------------
// tcsr_queue
// Small FIFO of classified column words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcsr_queue #(
  parameter int unsigned DEPTH = tcsr_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tcsr_pkg::tcsr_item_t  item_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output tcsr_pkg::tcsr_item_t  head_o
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tcsr_pkg::tcsr_item_t mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/tcsr_div.sv
// ----------------------------------------------------------------------------
// tcsr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcsr_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [tcsr_pkg::NW-1:0]       mag_i,
  input  logic [tcsr_pkg::DENW-1:0]     den_i,
  input  logic                          neg_i,
  output logic [tcsr_pkg::QB-1:0]       quo_o,
  output logic                          rem_nz_o,
  output logic                          neg_o
);

  localparam int NW   = tcsr_pkg::NW;
  localparam int DENW = tcsr_pkg::DENW;
  localparam int QB   = tcsr_pkg::QB;

  logic [NW-1:0]   rem_q [QB];
  logic [QB-1:0]   quo_q [QB];
  logic [DENW-1:0] den_q [QB-1];
  logic [QB-1:0]   neg_q;

  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int B = QB - 1 - i;
    logic [NW-1:0]   rem_in, cand;
    logic [QB-1:0]   quo_in;
    logic [DENW-1:0] den_in;
    logic            neg_in, ge;

    if (i == 0) begin : g_first
      assign rem_in = mag_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
      assign neg_in = neg_q[i-1];
    end

    assign cand = NW'(den_in) << B;
    assign ge   = (rem_in >= cand);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? (rem_in - cand) : rem_in;
        quo_q[i] <= quo_in | (QB'(ge) << B);
        neg_q[i] <= neg_in;
      end
    end

    if (i < QB - 1) begin : g_den
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign quo_o    = quo_q[QB-1];
  assign rem_nz_o = (rem_q[QB-1] != '0);
  assign neg_o    = neg_q[QB-1];

endmodule

### rtl/tcsr_back.sv
// ----------------------------------------------------------------------------
// tcsr_back
// Multiply, divide and round both edges, then register the span word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcsr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tcsr_pkg::tcsr_item_t               head_i,
  input  logic                               head_valid_i,
  output logic                               pop_o,
  input  logic [tcsr_pkg::COLOR_W-1:0]       color_i,
  tcsr_span_if.source                        span_o
);

  localparam int DW    = tcsr_pkg::DW;
  localparam int P1W   = tcsr_pkg::P1W;
  localparam int P2W   = tcsr_pkg::P2W;
  localparam int NW    = tcsr_pkg::NW;
  localparam int DENW  = tcsr_pkg::DENW;
  localparam int QB    = tcsr_pkg::QB;
  localparam int SW    = tcsr_pkg::SW;
  localparam int COL_W = tcsr_pkg::COL_W;
  localparam int ROW_W = tcsr_pkg::ROW_W;

  function automatic logic signed [ROW_W-1:0] sat_row(input logic signed [SW-1:0] v);
    logic signed [ROW_W-1:0] r;
    if (v < SW'(tcsr_pkg::ROW_MIN)) begin
      r = ROW_W'(tcsr_pkg::ROW_MIN);
    end else if (v > SW'(tcsr_pkg::ROW_MAX)) begin
      r = ROW_W'(tcsr_pkg::ROW_MAX);
    end else begin
      r = v[ROW_W-1:0];
    end
    return r;
  endfunction

  logic adv;
  assign adv   = !span_o.valid || span_o.ready;
  assign pop_o = adv && head_valid_i;

  // product stage
  logic                    s1_valid_q;
  logic signed [COL_W-1:0] s1_x_q;
  logic                    s1_go_q;
  logic signed [P1W-1:0]   p1_q [2];
  logic signed [P2W-1:0]   p2_q [2];
  logic signed [DW-1:0]    dx_q [2];

  // side data along the divider
  logic [QB-1:0]           dv_q;
  logic signed [COL_W-1:0] dx_x_q [QB];
  logic [QB-1:0]           dgo_q;

  logic [QB-1:0]           quo   [2];
  logic                    rem_nz [2];
  logic                    qneg  [2];
  logic signed [SW-1:0]    bnd   [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      dv_q         <= '0;
      span_o.valid <= 1'b0;
    end else if (adv) begin
      s1_valid_q   <= head_valid_i;
      dv_q         <= {dv_q[QB-2:0], s1_valid_q};
      span_o.valid <= dv_q[QB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q     <= head_i.x;
      s1_go_q    <= head_i.go;
      dx_x_q[0]  <= s1_x_q;
      dgo_q      <= {dgo_q[QB-2:0], s1_go_q};
      for (int k = 1; k < QB; k++) begin
        dx_x_q[k] <= dx_x_q[k-1];
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_seg
    logic signed [NW-1:0]  num_raw, num;
    logic [NW-1:0]         mag;
    logic [DW-1:0]         adx;
    logic [DENW-1:0]       den;
    logic                  nneg;
    logic signed [SW-1:0]  qe, rz;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        p1_q[g] <= P1W'(head_i.seg[g].py) * P1W'(head_i.seg[g].dx);
        p2_q[g] <= P2W'(head_i.seg[g].dy) * P2W'(head_i.seg[g].ofs);
        dx_q[g] <= head_i.seg[g].dx;
      end
    end

    // fold the sign of dx into the numerator, split sign and magnitude
    assign num_raw = NW'(p1_q[g]) + NW'(p2_q[g]);
    assign num     = (dx_q[g] < 0) ? -num_raw : num_raw;
    assign nneg    = (num < 0);
    assign mag     = nneg ? NW'(-num) : NW'(num);
    assign adx     = (dx_q[g] < 0) ? DW'(-dx_q[g]) : DW'(dx_q[g]);
    assign den     = DENW'(adx) << tcsr_pkg::COORD_FRAC_BITS;

    tcsr_div u_div (
      .clk_i    (clk_i),
      .en_i     (adv),
      .mag_i    (mag),
      .den_i    (den),
      .neg_i    (nneg),
      .quo_o    (quo[g]),
      .rem_nz_o (rem_nz[g]),
      .neg_o    (qneg[g])
    );

    assign qe = $signed(SW'(quo[g]));
    assign rz = $signed(SW'(rem_nz[g]));

    if (g == tcsr_pkg::SEG_LO) begin : g_ceil
      assign bnd[g] = qneg[g] ? -qe : (qe + rz);
    end else begin : g_floor
      assign bnd[g] = qneg[g] ? -(qe + rz) : qe;
    end
  end

  logic cov;
  assign cov = dgo_q[QB-1] && (bnd[tcsr_pkg::SEG_LO] <= bnd[tcsr_pkg::SEG_HI]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      span_o.column_out <= dx_x_q[QB-1];
      span_o.covered    <= cov;
      span_o.first_row  <= cov ? sat_row(bnd[tcsr_pkg::SEG_LO]) : '0;
      span_o.last_row   <= cov ? sat_row(bnd[tcsr_pkg::SEG_HI]) : '0;
      span_o.color      <= color_i;
    end
  end

endmodule

### rtl/triangle_column_span_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// Triangle column span rasterizer
// Turns one pixel column into the covered row span of a configured triangle.
// ----------------------------------------------------------------------------
// channel   dir  handshake          word
// col_i     in   valid/ready        column (12b signed)
// span_o    out  valid/ready        column_out, first_row, last_row, covered, color
// cfg       in   cfg_we_i, no wait  cfg_idx_i selects register, cfg_data_i value
//
// One column word per cycle while span_o is ready. Back pipeline: product stage,
// pipelined restoring divider with one quotient bit per stage, span register.
// Reset clears the registers to zero and empties the pipeline; no clearing pass.
// A stall on span_o freezes the back pipeline; col_i keeps taking words until
// the QUEUE_DEPTH-word queue between front and back is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "triangle_column_span_rasterizer_unit_assert.svh"

module triangle_column_span_rasterizer_unit #(
  parameter int unsigned QUEUE_DEPTH = tcsr_pkg::QUEUE_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tcsr_pkg::REG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tcsr_pkg::CFG_W-1:0]          cfg_data_i,
  tcsr_col_if.sink                            col_i,
  tcsr_span_if.source                         span_o
);

  localparam int CW = tcsr_pkg::CW;

  // configuration registers
  tcsr_pkg::tcsr_tri_t              tri_q;
  logic [tcsr_pkg::COLOR_W-1:0]     fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_q  <= '0;
      fill_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcsr_pkg::REG_VA_X: tri_q.va.x <= cfg_data_i[CW-1:0];
        tcsr_pkg::REG_VA_Y: tri_q.va.y <= cfg_data_i[CW-1:0];
        tcsr_pkg::REG_VB_X: tri_q.vb.x <= cfg_data_i[CW-1:0];
        tcsr_pkg::REG_VB_Y: tri_q.vb.y <= cfg_data_i[CW-1:0];
        tcsr_pkg::REG_VC_X: tri_q.vc.x <= cfg_data_i[CW-1:0];
        tcsr_pkg::REG_VC_Y: tri_q.vc.y <= cfg_data_i[CW-1:0];
        tcsr_pkg::REG_FILL: fill_q     <= cfg_data_i[tcsr_pkg::COLOR_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // front: classify the column and push it into the queue
  tcsr_pkg::tcsr_item_t front_item, head_item;
  logic q_full, q_empty, q_pop, q_push;

  tcsr_front u_front (
    .tri_i    (tri_q),
    .column_i (col_i.column),
    .item_o   (front_item)
  );

  assign col_i.ready = !q_full;
  assign q_push      = col_i.valid && !q_full;

  tcsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_item)
  );

  // back: edge arithmetic and output word register
  tcsr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_item),
    .head_valid_i (!q_empty),
    .pop_o        (q_pop),
    .color_i      (fill_q),
    .span_o       (span_o)
  );

  // a covered span is never empty
  `TCSR_ASSERT_NOW(a_cov_order, span_o.valid && span_o.covered, $signed(span_o.first_row) <= $signed(span_o.last_row))
  // an uncovered column reports zero rows
  `TCSR_ASSERT_NOW(a_uncov_zero, span_o.valid && !span_o.covered, span_o.first_row == '0 && span_o.last_row == '0)
  // the span color tracks the fill register
  `TCSR_ASSERT_NOW(a_color, span_o.valid && !cfg_we_i, span_o.color == fill_q)
  // the queue is never popped while empty
  `TCSR_ASSERT_NOW(a_no_underflow, q_empty, !q_pop)

endmodule

### test/triangle_column_span_rasterizer_unit_tb.sv
// ----------------------------------------------------------------------------
// Span rasterizer testbench
// Drives column words against a set of triangles, directed and random, and
// compares every span word with a behavioral span calculator kept here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_column_span_rasterizer_unit_tb;
  import tcsr_pkg::*;

  typedef struct {
    logic signed [COL_W-1:0] col;
    logic signed [ROW_W-1:0] first;
    logic signed [ROW_W-1:0] last;
    logic                    cov;
    logic [COLOR_W-1:0]      color;
  } span_t;

  // one row of the directed table: which triangle, which column, and
  // whether the span is typed in (always "not covered" for those rows)
  typedef struct {
    int          tri_sel;
    int          col;
    bit          typed;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx_i = REG_VA_X;
  logic [CFG_W-1:0] cfg_data_i = '0;

  tcsr_col_if  col_bus();
  tcsr_span_if span_bus();

  triangle_column_span_rasterizer_unit u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .col_i(col_bus), .span_o(span_bus)
  );

  // shadow of the register file
  logic signed [CW-1:0] vert_x [3];
  logic signed [CW-1:0] vert_y [3];
  logic [COLOR_W-1:0]   fill_q;

  span_t span_q [$];
  int    fail_cnt = 0;
  bit    no_idle = 0;
  bit    hold_req = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint floor_q(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  // row bound of edge p->q at fixed-point column cx; ceiling when up
  function automatic longint edge_bound(longint px, longint py, longint qx, longint qy,
                                        longint cx, bit up);
    longint dx, num, den;
    dx  = qx - px;
    num = py * dx + (qy - py) * (cx - px);
    den = dx * (longint'(1) << COORD_FRAC_BITS);
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    return up ? -floor_q(-num, den) : floor_q(num, den);
  endfunction

  function automatic longint clamp_row(longint r);
    return (r < ROW_MIN) ? ROW_MIN : (r > ROW_MAX) ? ROW_MAX : r;
  endfunction

  function automatic span_t column_span(logic signed [COL_W-1:0] col);
    longint vx [3], vy [3], ax, ay, bx, by, cx, cy;
    longint lx0, ly0, lx1, ly1, hx0, hy0, hx1, hy1, right, xf, f, l;
    int     lead;
    bit     ok;
    span_t  s;
    for (int i = 0; i < 3; i++) begin
      vx[i] = longint'(vert_x[i]);
      vy[i] = longint'(vert_y[i]);
    end
    xf = longint'(col) * (longint'(1) << COORD_FRAC_BITS);
    // rotate so the left-most vertex leads, ties to a then b
    if (vx[0] <= vx[1] && vx[0] <= vx[2]) lead = 0;
    else if (vx[1] <= vx[0] && vx[1] <= vx[2]) lead = 1;
    else lead = 2;
    ax = vx[lead];         ay = vy[lead];
    bx = vx[(lead+1) % 3]; by = vy[(lead+1) % 3];
    cx = vx[(lead+2) % 3]; cy = vy[(lead+2) % 3];
    ok = 1;
    if (ax == cx) begin
      right = bx; lx0 = ax; ly0 = ay; lx1 = bx; ly1 = by;
      hx0 = cx; hy0 = cy; hx1 = bx; hy1 = by;
      if (ax == bx) ok = 0;
    end else if (ax == bx) begin
      right = cx; lx0 = bx; ly0 = by; lx1 = cx; ly1 = cy;
      hx0 = ax; hy0 = ay; hx1 = cx; hy1 = cy;
    end else if (bx == cx) begin
      right = cx; lx0 = ax; ly0 = ay; lx1 = bx; ly1 = by;
      hx0 = ax; hy0 = ay; hx1 = cx; hy1 = cy;
    end else if (bx < cx) begin
      // bend of the lower edge at b
      right = cx; hx0 = ax; hy0 = ay; hx1 = cx; hy1 = cy;
      if (xf <= bx) begin
        lx0 = ax; ly0 = ay; lx1 = bx; ly1 = by;
      end else begin
        lx0 = bx; ly0 = by; lx1 = cx; ly1 = cy;
      end
    end else begin
      // bend of the upper edge at c
      right = bx; lx0 = ax; ly0 = ay; lx1 = bx; ly1 = by;
      if (xf <= cx) begin
        hx0 = ax; hy0 = ay; hx1 = cx; hy1 = cy;
      end else begin
        hx0 = cx; hy0 = cy; hx1 = bx; hy1 = by;
      end
    end
    s.col = col;
    s.first = '0;
    s.last = '0;
    s.cov = 1'b0;
    s.color = fill_q;
    if (ok && xf >= ax && xf <= right && lx0 != lx1 && hx0 != hx1) begin
      f = edge_bound(lx0, ly0, lx1, ly1, xf, 1'b1);
      l = edge_bound(hx0, hy0, hx1, hy1, xf, 1'b0);
      if (f <= l) begin
        s.cov = 1'b1;
        s.first = ROW_W'(clamp_row(f));
        s.last = ROW_W'(clamp_row(l));
      end
    end
    return s;
  endfunction

  // ---------------------------------------------------------- config writes
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drain the pipe, then load a whole triangle and its color
  task automatic load_triangle(int ax, int ay, int bx, int by, int cx, int cy,
                               logic [COLOR_W-1:0] rgb);
    wait (span_q.size() == 0);
    @(negedge clk_i);
    write_reg(REG_VA_X, CFG_W'(ax));
    write_reg(REG_VA_Y, CFG_W'(ay));
    write_reg(REG_VB_X, CFG_W'(bx));
    write_reg(REG_VB_Y, CFG_W'(by));
    write_reg(REG_VC_X, CFG_W'(cx));
    write_reg(REG_VC_Y, CFG_W'(cy));
    write_reg(REG_FILL, rgb);
    vert_x[0] = CW'(ax); vert_y[0] = CW'(ay);
    vert_x[1] = CW'(bx); vert_y[1] = CW'(by);
    vert_x[2] = CW'(cx); vert_y[2] = CW'(cy);
    fill_q = rgb;
  endtask

  // random triangle; mostly small, mostly clockwise, sometimes vertical edges
  task automatic load_random_triangle();
    int x [3], y [3], span, t;
    longint cr;
    span = ($urandom_range(9) == 0) ? 32767 : $urandom_range(60, 1200);
    for (int i = 0; i < 3; i++) begin
      x[i] = $urandom_range(2 * span) - span;
      y[i] = $urandom_range(2 * span) - span;
    end
    if ($urandom_range(4) == 0) x[$urandom_range(2)] = x[$urandom_range(2)];
    cr = longint'(x[1] - x[0]) * (y[2] - y[0]) - longint'(y[1] - y[0]) * (x[2] - x[0]);
    if (cr < 0 && $urandom_range(9) != 0) begin
      t = x[1]; x[1] = x[2]; x[2] = t;
      t = y[1]; y[1] = y[2]; y[2] = t;
    end
    load_triangle(x[0], y[0], x[1], y[1], x[2], y[2], COLOR_W'($urandom));
  endtask

  // ------------------------------------------------------------ column sender
  task automatic send_column(logic signed [COL_W-1:0] col, bit typed);
    span_t s;
    while (!no_idle && $urandom_range(99) < 34) begin
      col_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    col_bus.valid <= 1'b1;
    col_bus.column <= col;
    do @(posedge clk_i); while (!col_bus.ready);
    // predict with the registers as they stand at acceptance
    s = column_span(col);
    if (typed) begin
      s.first = '0;
      s.last = '0;
      s.cov = 1'b0;
    end
    span_q.push_back(s);
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------- span receiver
  initial begin
    span_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // hold off long enough to fill the queue and back up col_i
        hold_req = 0;
        span_bus.ready <= 1'b0;
        repeat (200) @(negedge clk_i);
      end
      span_bus.ready <= no_idle || ($urandom_range(99) >= 34);
    end
  end

  // compare each span word with the oldest prediction
  always @(posedge clk_i) begin
    span_t e;
    if (rst_ni && span_bus.valid && span_bus.ready) begin
      if (span_q.size() == 0) begin
        $display("%0t: unexpected span word column %0d", $time, span_bus.column_out);
        fail_cnt++;
      end else begin
        e = span_q.pop_front();
        if (span_bus.column_out !== e.col || span_bus.first_row !== e.first ||
            span_bus.last_row !== e.last || span_bus.covered !== e.cov ||
            span_bus.color !== e.color) begin
          $display("%0t: span mismatch exp col %0d rows %0d..%0d cov %0b rgb %06h",
                   $time, e.col, e.first, e.last, e.cov, e.color);
          $display("%0t:                act col %0d rows %0d..%0d cov %0b rgb %06h",
                   $time, span_bus.column_out, span_bus.first_row, span_bus.last_row,
                   span_bus.covered, span_bus.color);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  vector_t vectors [] = '{
    // zero-width triangle after reset: nothing covered
    '{0, -2048, 1}, '{0, 2047, 1}, '{0, 0, 1}, '{0, -1, 1},
    // plain clockwise triangle, bend of the lower edge at b
    '{1, -1, 0}, '{1, 0, 0}, '{1, 5, 0}, '{1, 10, 0}, '{1, 15, 0}, '{1, 20, 0},
    '{1, 21, 0},
    // vertical left edge
    '{2, 0, 0}, '{2, 4, 0}, '{2, 10, 0}, '{2, 11, 0},
    // full-range triangle with a vertical right edge
    '{3, -2048, 0}, '{3, 2047, 0}, '{3, 0, 0}, '{3, -1, 0},
    // fractional vertices, bend of the upper edge at c
    '{4, 0, 0}, '{4, 2, 0}, '{4, 3, 0}, '{4, 4, 0}, '{4, 6, 0}
  };

  initial begin
    int cur_tri, lo, hi, minx, maxx;
    logic signed [COL_W-1:0] col;
    col_bus.valid = 1'b0;
    col_bus.column = '0;
    for (int i = 0; i < 3; i++) begin
      vert_x[i] = '0;
      vert_y[i] = '0;
    end
    fill_q = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    cur_tri = 0;
    foreach (vectors[i]) begin
      if (vectors[i].tri_sel != cur_tri) begin
        cur_tri = vectors[i].tri_sel;
        col_bus.valid <= 1'b0;
        case (cur_tri)
          1: load_triangle(0, 0, 160, -80, 320, 160, 24'hff8000);
          2: load_triangle(0, 160, 0, 0, 160, 80, 24'h00ff7f);
          3: load_triangle(-32768, -32768, 32767, -32768, 32767, 32767, 24'hffffff);
          default: load_triangle(5, 3, 110, 41, 70, -20, 24'h123456);
        endcase
      end
      send_column(COL_W'(vectors[i].col), vectors[i].typed);
    end

    // random part: fresh triangle every ~90 words
    for (int n = 0; n < 900; n++) begin
      if (n % 90 == 0) begin
        col_bus.valid <= 1'b0;
        if (n == 450) load_triangle(32767, 32767, -32768, -32768, 32767, -32768, 24'h000000);
        else load_random_triangle();
      end
      if (n == 200) hold_req = 1;
      no_idle = (n >= 300 && n < 400);
      if (n == 600) begin
        // let every span drain before going on
        col_bus.valid <= 1'b0;
        wait (span_q.size() == 0);
        @(negedge clk_i);
      end
      minx = int'(vert_x[0]); maxx = int'(vert_x[0]);
      for (int i = 1; i < 3; i++) begin
        if (int'(vert_x[i]) < minx) minx = int'(vert_x[i]);
        if (int'(vert_x[i]) > maxx) maxx = int'(vert_x[i]);
      end
      lo = (minx >>> COORD_FRAC_BITS) - 2;
      hi = (maxx >>> COORD_FRAC_BITS) + 2;
      if (lo < -2048) lo = -2048;
      if (hi > 2047) hi = 2047;
      if ($urandom_range(9) < 8) col = COL_W'(lo + int'($urandom_range(hi - lo)));
      else col = COL_W'($urandom);
      send_column(col, 1'b0);
    end
    col_bus.valid <= 1'b0;
    no_idle = 0;

    wait (span_q.size() == 0);
    repeat (QB + 20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
